// ----- rtl/pbp_pkg.sv -----
// Shared types and constants for the perceptron branch predictor.
`default_nettype none

package pbp_pkg;

	// Default sizes of the weight table and history.
	localparam int DEF_ROWS        = 512;
	localparam int DEF_HISTORY_LEN = 30;
	localparam int DEF_WEIGHT_BITS = 8;

	// Fixed field widths and limits.
	localparam int PC_W   = 32;
	localparam int THR_W  = 8;
	localparam int SUM_W  = 13;
	localparam int SUM_MAX = 4095;
	localparam int SUM_MIN = -4096;

	localparam logic [THR_W-1:0] THRESH_RESET = 8'd73;

	// Command queue depth between front and back.
	localparam int QDEPTH = 4;

	// Weights handled per cycle by the back datapath.
	localparam int LANES = 8;

	// Program counter bits consumed per cycle by the row reduction.
	localparam int MOD_BITS  = 4;
	localparam int MOD_STEPS = PC_W / MOD_BITS;

	// One classified command as it travels through the queue.
	typedef struct packed {
		logic            resolve;
		logic [PC_W-1:0] pc;
		logic            taken;
		logic            pred_dir;
	} cmd_t;

	// Queue fill status seen by front and back.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// Back sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_READ,
		ST_LOAD,
		ST_STEP,
		ST_FINISH
	} back_state_t;

endpackage

`default_nettype wire

// ----- rtl/pbp_front.sv -----
// Front end: command acceptance, classification and the threshold register.
`default_nettype none

module pbp_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        req_type,
	input  wire logic [pbp_pkg::PC_W-1:0]    pc,
	input  wire logic                        taken,
	input  wire logic                        pred_dir,
	input  wire logic                        cfg_we,
	input  wire logic [pbp_pkg::THR_W-1:0]   cfg_wdata,
	input  wire pbp_pkg::queue_status_t      qstat,
	input  wire logic                        clearing,
	output logic                             busy,
	output logic                             push,
	output pbp_pkg::cmd_t                    cmd,
	output logic [pbp_pkg::THR_W-1:0]        threshold
);
	import pbp_pkg::*;

	logic [THR_W-1:0] threshold_q;

	// Hold off new transactions while the queue is full or the table is being cleared.
	assign busy = qstat.full | clearing;
	assign push = start & ~busy;

	// Classify the transaction; direction fields only matter for a resolve.
	always_comb begin
		cmd.resolve  = req_type;
		cmd.pc       = pc;
		cmd.taken    = req_type & taken;
		cmd.pred_dir = req_type & pred_dir;
	end

	// Training threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESH_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	assign threshold = threshold_q;

endmodule

`default_nettype wire

// ----- rtl/pbp_queue.sv -----
// Small command queue between the front end and the back end.
`default_nettype none

module pbp_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire pbp_pkg::cmd_t          wdata,
	input  wire logic                   pop,
	output pbp_pkg::cmd_t               head,
	output pbp_pkg::queue_status_t      qstat
);
	import pbp_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	cmd_t             entries_q [QDEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;

	// Entry storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head        = entries_q[rptr_q];
	assign qstat.full  = (count_q == CNT_W'(QDEPTH));
	assign qstat.empty = (count_q == '0);

endmodule

`default_nettype wire

// ----- rtl/pbp_back.sv -----
// Back end: weight memory, serial dot product, training and history.
`default_nettype none

module pbp_back #(
	parameter int ROWS        = pbp_pkg::DEF_ROWS,
	parameter int HISTORY_LEN = pbp_pkg::DEF_HISTORY_LEN,
	parameter int WEIGHT_BITS = pbp_pkg::DEF_WEIGHT_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire pbp_pkg::queue_status_t           qstat,
	input  wire pbp_pkg::cmd_t                    head,
	input  wire logic [pbp_pkg::THR_W-1:0]        threshold,
	output logic                                  pop,
	output logic                                  clearing,
	output logic                                  done,
	output logic                                  prediction,
	output logic signed [pbp_pkg::SUM_W-1:0]      sum_value
);
	import pbp_pkg::*;

	localparam int WB        = WEIGHT_BITS;
	localparam int COLS      = HISTORY_LEN + 1;
	localparam int NSTEP     = (COLS + LANES - 1) / LANES;
	localparam int COLSP     = NSTEP * LANES;
	localparam int ROW_BITS  = COLS * WB;
	localparam int ROWP_BITS = COLSP * WB;
	localparam int LANE_BITS = LANES * WB;
	localparam int ROW_W     = $clog2(ROWS);
	localparam int ACC_RAW   = WB + $clog2(COLSP) + 1;
	localparam int ACC_W     = (ACC_RAW > SUM_W + 1) ? ACC_RAW : SUM_W + 1;
	localparam int STEP_W    = $clog2(NSTEP + 1);
	localparam int MODC_W    = $clog2(MOD_STEPS);
	localparam bit ROWS_POW2 = ((ROWS & (ROWS - 1)) == 0);

	localparam logic [ROW_W:0]            ROWS_V  = (ROW_W + 1)'(ROWS);
	localparam logic signed [WB-1:0]      W_MAX   = {1'b0, {(WB - 1){1'b1}}};
	localparam logic signed [WB-1:0]      W_MIN   = {1'b1, {(WB - 1){1'b0}}};
	localparam logic signed [ACC_W-1:0]   ACC_MAX = ACC_W'(SUM_MAX);
	localparam logic signed [ACC_W-1:0]   ACC_MIN = ACC_W'(SUM_MIN);

	// Weight memory, one row per word, cleared by a sweep after reset.
	logic [ROW_BITS-1:0] mem [ROWS];
	logic [ROW_BITS-1:0] rdata_q;

	back_state_t               state_q, state_d;
	cmd_t                      op_q;
	logic [ROW_W-1:0]          row_q;
	logic [ROW_W:0]            modr_q;
	logic [PC_W-1:0]           modpc_q;
	logic [MODC_W-1:0]         modc_q;
	logic [ROW_W-1:0]          clr_q;
	logic [ROWP_BITS-1:0]      wrow_q;
	logic [COLSP-1:0]          xh_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic [STEP_W-1:0]         step_q;
	logic [HISTORY_LEN-1:0]    hist_q;
	logic signed [SUM_W-1:0]   last_sum_q;
	logic                      train_q;
	logic                      done_q;
	logic                      pred_q;
	logic signed [SUM_W-1:0]   sumo_q;

	logic                      mem_re;
	logic                      mem_we;
	logic [ROW_W-1:0]          mem_waddr;
	logic [ROW_BITS-1:0]       mem_wdata;
	logic                      mod_last;
	logic                      step_last;
	logic [ROW_W:0]            mod_r;
	logic signed [ACC_W-1:0]   part;
	logic [LANE_BITS-1:0]      lane_new;
	logic signed [SUM_W-1:0]   sat_sum;
	logic [SUM_W-1:0]          mag;
	logic                      train_d;

	assign mod_last  = (modc_q == MODC_W'(MOD_STEPS - 1));
	assign step_last = (step_q == STEP_W'(NSTEP - 1));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == ROW_W'(ROWS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!qstat.empty) begin
					state_d = ROWS_POW2 ? ST_READ : ST_MOD;
				end
			end
			ST_MOD: begin
				if (mod_last) begin
					state_d = ST_READ;
				end
			end
			ST_READ:   state_d = ST_LOAD;
			ST_LOAD:   state_d = ST_STEP;
			ST_STEP: begin
				if (step_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		pop       = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = row_q;
		mem_wdata = wrow_q[ROW_BITS-1:0];
		clearing  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				clearing  = 1'b1;
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE:   pop    = !qstat.empty;
			ST_READ:   mem_re = 1'b1;
			ST_FINISH: mem_we = op_q.resolve & train_q;
			default: begin
			end
		endcase
	end

	// Row index reduction for a row count that is not a power of two.
	always_comb begin
		mod_r = modr_q;
		for (int i = 0; i < MOD_BITS; i++) begin
			mod_r = {mod_r[ROW_W-1:0], modpc_q[PC_W-1-i]};
			if (mod_r >= ROWS_V) begin
				mod_r = mod_r - ROWS_V;
			end
		end
	end

	// One group of lanes: signed partial sum for predict, saturating nudge for training.
	always_comb begin
		logic signed [WB-1:0] lw;
		logic signed [WB-1:0] nw;
		logic                 up;
		part     = '0;
		lane_new = '0;
		for (int i = 0; i < LANES; i++) begin
			lw = signed'(wrow_q[i*WB +: WB]);
			if (xh_q[i]) begin
				part = part + ACC_W'(lw);
			end else begin
				part = part - ACC_W'(lw);
			end
			up = (op_q.taken == xh_q[i]);
			if (up) begin
				nw = (lw == W_MAX) ? lw : lw + 1'b1;
			end else begin
				nw = (lw == W_MIN) ? lw : lw - 1'b1;
			end
			lane_new[i*WB +: WB] = op_q.resolve ? nw : lw;
		end
	end

	// Clamp the accumulated sum to the output range.
	always_comb begin
		if (acc_q > ACC_MAX) begin
			sat_sum = SUM_W'(SUM_MAX);
		end else if (acc_q < ACC_MIN) begin
			sat_sum = SUM_W'(SUM_MIN);
		end else begin
			sat_sum = acc_q[SUM_W-1:0];
		end
	end

	// Training decision from the kept sum.
	always_comb begin
		mag     = last_sum_q[SUM_W-1] ? (SUM_W'(0) - SUM_W'(last_sum_q)) : SUM_W'(last_sum_q);
		train_d = (op_q.taken != op_q.pred_dir) || (mag <= SUM_W'(threshold));
	end

	// Memory write port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	// Memory read port with registered data.
	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= mem[row_q];
		end
	end

	// Datapath registers; payload only, no reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_q    <= head;
				row_q   <= head.pc[ROW_W-1:0];
				modr_q  <= '0;
				modpc_q <= head.pc;
			end
			ST_MOD: begin
				modr_q  <= mod_r;
				modpc_q <= modpc_q << MOD_BITS;
				row_q   <= mod_r[ROW_W-1:0];
			end
			ST_LOAD: begin
				wrow_q  <= ROWP_BITS'(rdata_q);
				xh_q    <= COLSP'({hist_q, 1'b1});
				acc_q   <= '0;
				train_q <= train_d;
			end
			ST_STEP: begin
				acc_q  <= acc_q + part;
				wrow_q <= (wrow_q >> LANE_BITS)
					| (ROWP_BITS'(lane_new) << (ROWP_BITS - LANE_BITS));
				xh_q   <= (xh_q >> LANES) | (COLSP'(xh_q[LANES-1:0]) << (COLSP - LANES));
			end
			ST_FINISH: begin
				pred_q <= ~sat_sum[SUM_W-1];
				sumo_q <= sat_sum;
			end
			default: begin
			end
		endcase
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			modc_q     <= '0;
			step_q     <= '0;
			hist_q     <= '0;
			last_sum_q <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FINISH) && !op_q.resolve;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_IDLE) begin
				modc_q <= '0;
			end else if (state_q == ST_MOD) begin
				modc_q <= modc_q + 1'b1;
			end
			if (state_q == ST_LOAD) begin
				step_q <= '0;
			end else if (state_q == ST_STEP) begin
				step_q <= step_q + 1'b1;
			end
			if (state_q == ST_FINISH) begin
				if (op_q.resolve) begin
					hist_q <= {op_q.taken, hist_q[HISTORY_LEN-1:1]};
				end else begin
					last_sum_q <= sat_sum;
				end
			end
		end
	end

	assign done       = done_q;
	assign prediction = pred_q;
	assign sum_value  = sumo_q;

endmodule

`default_nettype wire

// ----- rtl/perceptron_branch_predictor.sv -----
// Top level of the perceptron branch predictor with global history.
//
//   Channel   Signals                              Transfer
//   command   start, busy, req_type, pc,           accepted when start && !busy
//             taken, pred_dir
//   result    done, prediction, sum_value          one cycle, marked by done
//   config    cfg_we, cfg_wdata                    written when cfg_we is high
//
// After reset the weight table is cleared one row per cycle, with busy held high;
// configuration writes are taken during that time. The back end handles one
// transaction at a time: the row read, a walk over the row eight weights per cycle,
// and a finish state. A row count that is not a power of two adds a row reduction
// before the read. A predict result appears in the cycle after its finish. The
// command queue takes up to four transactions ahead of the back end; busy rises
// when it is full or while the table is being cleared.
`default_nettype none

module perceptron_branch_predictor #(
	parameter int ROWS        = pbp_pkg::DEF_ROWS,
	parameter int HISTORY_LEN = pbp_pkg::DEF_HISTORY_LEN,
	parameter int WEIGHT_BITS = pbp_pkg::DEF_WEIGHT_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic                             req_type,
	input  wire logic [pbp_pkg::PC_W-1:0]         pc,
	input  wire logic                             taken,
	input  wire logic                             pred_dir,
	input  wire logic                             cfg_we,
	input  wire logic [pbp_pkg::THR_W-1:0]        cfg_wdata,
	output logic                                  done,
	output logic                                  prediction,
	output logic signed [pbp_pkg::SUM_W-1:0]      sum_value
);
	import pbp_pkg::*;

	queue_status_t    qstat;
	cmd_t             cmd;
	cmd_t             head;
	logic             push;
	logic             pop;
	logic             clearing;
	logic [THR_W-1:0] threshold;

	// Acceptance and classification.
	pbp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (req_type),
		.pc        (pc),
		.taken     (taken),
		.pred_dir  (pred_dir),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.qstat     (qstat),
		.clearing  (clearing),
		.busy      (busy),
		.push      (push),
		.cmd       (cmd),
		.threshold (threshold)
	);

	// Decoupling queue.
	pbp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	// Execution of predict and resolve transactions.
	pbp_back #(
		.ROWS        (ROWS),
		.HISTORY_LEN (HISTORY_LEN),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.head       (head),
		.threshold  (threshold),
		.pop        (pop),
		.clearing   (clearing),
		.done       (done),
		.prediction (prediction),
		.sum_value  (sum_value)
	);

	// No transaction enters the queue while the table is being cleared.
	a_no_push_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !push)
		else $error("command accepted during table clear");

	// The back end never pops an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty command queue");

	// A full queue never takes another transaction.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !push)
		else $error("push into full command queue");

	// Results never arrive in back-to-back cycles.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the perceptron branch predictor with global history.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pbp_pkg::*;

	localparam int ROWS = DEF_ROWS;
	localparam int HL   = DEF_HISTORY_LEN;
	localparam int WB   = DEF_WEIGHT_BITS;

	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 180;
	localparam int NUM_PHASES   = 5;

	localparam logic REQ_PREDICT = 1'b0;
	localparam logic REQ_RESOLVE = 1'b1;

	localparam logic signed [WB-1:0] W_HI = WB'((1 << (WB - 1)) - 1);
	localparam logic signed [WB-1:0] W_LO = WB'(-(1 << (WB - 1)));

	// Rows that the random part trains over and over.
	localparam int unsigned HOT_ROWS [4] = '{0, 1, 257, ROWS - 1};

	// Thresholds of the random phases; the last phase picks one at random.
	localparam int PHASE_THRESH [NUM_PHASES] = '{0, 255, 1, 73, 0};

	typedef struct packed {
		logic                    dir;
		logic signed [SUM_W-1:0] sum;
	} lookup_t;

	typedef struct packed {
		logic                    req;
		logic [PC_W-1:0]         addr;
		logic                    outcome;
		logic                    guessed;
		logic                    fixed;
		logic                    fx_dir;
		logic signed [SUM_W-1:0] fx_sum;
	} probe_t;

	// Directed transactions; typed results only where the row is still all zero.
	localparam probe_t PROBES [20] = '{
		'{REQ_PREDICT, 32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b1, 13'sd0},
		'{REQ_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 13'sd0},
		'{REQ_PREDICT, 32'h8000_0200, 1'b0, 1'b1, 1'b1, 1'b1, 13'sd0},
		'{REQ_RESOLVE, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0, 13'sd0},
		'{REQ_PREDICT, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 13'sd0},
		'{REQ_RESOLVE, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0, 13'sd0},
		'{REQ_PREDICT, 32'h0000_01FF, 1'b1, 1'b0, 1'b1, 1'b1, 13'sd0},
		'{REQ_RESOLVE, 32'h0000_01FF, 1'b1, 1'b0, 1'b0, 1'b0, 13'sd0},
		'{REQ_PREDICT, 32'h0000_01FF, 1'b0, 1'b0, 1'b0, 1'b0, 13'sd0},
		'{REQ_PREDICT, 32'hAAAA_AAAA, 1'b1, 1'b0, 1'b1, 1'b1, 13'sd0},
		'{REQ_PREDICT, 32'h5555_5555, 1'b0, 1'b1, 1'b1, 1'b1, 13'sd0},
		'{REQ_RESOLVE, 32'h5555_5555, 1'b0, 1'b0, 1'b0, 1'b0, 13'sd0},
		'{REQ_PREDICT, 32'h5555_5555, 1'b0, 1'b0, 1'b0, 1'b0, 13'sd0},
		'{REQ_RESOLVE, 32'hFFFF_FE00, 1'b1, 1'b0, 1'b0, 1'b0, 13'sd0},
		'{REQ_RESOLVE, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0, 13'sd0},
		'{REQ_PREDICT, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0, 13'sd0},
		'{REQ_RESOLVE, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 13'sd0},
		'{REQ_PREDICT, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0, 13'sd0},
		'{REQ_RESOLVE, 32'h0000_01FF, 1'b0, 1'b0, 1'b0, 1'b0, 13'sd0},
		'{REQ_PREDICT, 32'h0000_03FF, 1'b1, 1'b1, 1'b0, 1'b0, 13'sd0}
	};

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    req_type;
	logic [PC_W-1:0]         pc;
	logic                    taken;
	logic                    pred_dir;
	logic                    cfg_we;
	logic [THR_W-1:0]        cfg_wdata;
	logic                    done;
	logic                    prediction;
	logic signed [SUM_W-1:0] sum_value;

	// Predictor state, kept in step with every accepted transaction.
	logic signed [WB-1:0]    weights [ROWS][HL+1];
	logic [HL-1:0]           history;
	logic signed [SUM_W-1:0] kept_sum;
	logic [THR_W-1:0]        train_thresh;
	logic                    model_dir;

	lookup_t pending_lookups [$];
	lookup_t seen;
	int      errors;
	int      items_sent;
	int      idle_pct;
	int      cycles;

	perceptron_branch_predictor i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.pc         (pc),
		.taken      (taken),
		.pred_dir   (pred_dir),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.prediction (prediction),
		.sum_value  (sum_value)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Move one weight by one step toward up or down, holding at its limits.
	function automatic logic signed [WB-1:0] nudge_weight(input logic signed [WB-1:0] w,
			input logic up);
		if (up && w != W_HI)
			return w + 1;
		if (!up && w != W_LO)
			return w - 1;
		return w;
	endfunction

	// Update the predictor with one accepted transaction and queue any lookup result.
	task automatic apply_txn(input logic req, input logic [PC_W-1:0] addr, input logic outcome,
			input logic guessed);
		int unsigned row;
		int          acc;
		int          mag;
		lookup_t     res;
		row = addr % ROWS;
		if (req == REQ_PREDICT) begin
			acc = weights[row][0];
			for (int j = 0; j < HL; j++) begin
				if (history[j])
					acc += weights[row][j+1];
				else
					acc -= weights[row][j+1];
			end
			if (acc > SUM_MAX)
				acc = SUM_MAX;
			if (acc < SUM_MIN)
				acc = SUM_MIN;
			kept_sum = acc[SUM_W-1:0];
			model_dir = (acc >= 0);
			res.dir = model_dir;
			res.sum = kept_sum;
			pending_lookups.push_back(res);
		end else begin
			mag = (kept_sum < 0) ? -int'(kept_sum) : int'(kept_sum);
			if (outcome != guessed || mag <= int'(train_thresh)) begin
				weights[row][0] = nudge_weight(weights[row][0], outcome);
				for (int j = 0; j < HL; j++)
					weights[row][j+1] = nudge_weight(weights[row][j+1],
						outcome == history[j]);
			end
			history = {outcome, history[HL-1:1]};
		end
	endtask

	// Offer one transaction, entered and left at a falling edge.
	task automatic send_txn(input logic req, input logic [PC_W-1:0] addr, input logic outcome,
			input logic guessed);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		pc <= addr;
		taken <= outcome;
		pred_dir <= guessed;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
		apply_txn(req, addr, outcome, guessed);
		items_sent++;
	endtask

	// Stop sending and let every expected lookup and the back end drain.
	task automatic settle();
		start <= 1'b0;
		while (pending_lookups.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		train_thresh = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Address mostly in one of the trained rows, else in any row, with random upper bits.
	function automatic logic [PC_W-1:0] hot_pc();
		int unsigned pick;
		int unsigned row;
		pick = $urandom_range(0, 4);
		row = (pick < 4) ? HOT_ROWS[pick] : $urandom_range(0, ROWS - 1);
		return (PC_W'($urandom()) & ~PC_W'(ROWS - 1)) | PC_W'(row);
	endfunction

	// Checker for lookup results.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_lookups.size() == 0) begin
				$error("sum_value: expected no result, actual %0d", sum_value);
				errors++;
			end else begin
				seen = pending_lookups.pop_front();
				if (prediction !== seen.dir) begin
					$error("prediction: expected %0d, actual %0d", seen.dir, prediction);
					errors++;
				end
				if (sum_value !== seen.sum) begin
					$error("sum_value: expected %0d, actual %0d", seen.sum, sum_value);
					errors++;
				end
			end
		end
	end

	initial begin
		logic [PC_W-1:0] addr;
		logic            outcome;
		logic            guessed;
		logic            alternate;
		int              kind;
		int              target;
		int              thr;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_PREDICT;
		pc = '0;
		taken = 1'b0;
		pred_dir = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		errors = 0;
		items_sent = 0;
		cycles = 0;
		idle_pct = 10;
		foreach (weights[r, c])
			weights[r][c] = '0;
		history = '0;
		kept_sum = '0;
		train_thresh = THRESH_RESET;
		model_dir = 1'b0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset threshold.
		foreach (PROBES[i]) begin
			send_txn(PROBES[i].req, PROBES[i].addr, PROBES[i].outcome, PROBES[i].guessed);
			if (PROBES[i].fixed)
				pending_lookups[pending_lookups.size()-1] = '{PROBES[i].fx_dir,
					PROBES[i].fx_sum};
		end

		// Random phases, each at its own threshold.
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			thr = (p == NUM_PHASES - 1) ? $urandom_range(2, 254) : PHASE_THRESH[p];
			write_threshold(THR_W'(thr));
			idle_pct = (p == 1) ? 0 : 10;
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				kind = $urandom_range(0, 99);
				if (kind < 75) begin
					// Lookup followed by its resolve, mostly with the looked-up direction.
					addr = hot_pc();
					send_txn(REQ_PREDICT, addr, 1'($urandom()), 1'($urandom()));
					outcome = ($urandom_range(0, 99) < 80) ? ^addr[8:0] : !(^addr[8:0]);
					guessed = ($urandom_range(0, 99) < 5) ? !model_dir : model_dir;
					send_txn(REQ_RESOLVE, addr, outcome, guessed);
				end else if (kind < 78) begin
					// Long run of mispredicted resolves on one row to drive weights to
					// their limits, then a lookup of that row.
					addr = hot_pc();
					alternate = 1'($urandom());
					outcome = 1'($urandom());
					repeat ($urandom_range(20, 160)) begin
						send_txn(REQ_RESOLVE, addr, outcome, !outcome);
						if (alternate)
							outcome = !outcome;
					end
					send_txn(REQ_PREDICT, addr, 1'($urandom()), 1'($urandom()));
				end else begin
					// Unrelated transaction anywhere in the table.
					send_txn(1'($urandom()), PC_W'($urandom()), 1'($urandom()),
						1'($urandom()));
				end
			end
		end

		settle();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
